// ----- rtl/core/cpd_pkg.sv -----
// Shared types, codes and reset values of the coordinate packet deframer.
`default_nettype none
package cpd_pkg;

    typedef logic signed [31:0] coord_t;

    localparam int APB_AW = 5;

    localparam logic [7:0] HDR_BYTE = 8'hFF;

    localparam logic [3:0] POS_HUNT   = 4'd0;
    localparam logic [3:0] POS_UNUSED = 4'd1;
    localparam logic [3:0] POS_CMD    = 4'd2;
    localparam logic [3:0] POS_X_LAST = 4'd6;
    localparam logic [3:0] POS_Y_LAST = 4'd10;
    localparam logic [3:0] POS_LAST   = 4'd15;

    localparam logic [2:0] REG_X_MIN = 3'd0;
    localparam logic [2:0] REG_X_MAX = 3'd1;
    localparam logic [2:0] REG_Y_MIN = 3'd2;
    localparam logic [2:0] REG_Y_MAX = 3'd3;
    localparam logic [2:0] REG_Z_MIN = 3'd4;
    localparam logic [2:0] REG_Z_MAX = 3'd5;

    localparam coord_t X_MIN_RST = -32'sd400;
    localparam coord_t X_MAX_RST = 32'sd400;
    localparam coord_t Y_MIN_RST = 32'sd0;
    localparam coord_t Y_MAX_RST = 32'sd400;
    localparam coord_t Z_MIN_RST = -32'sd400;
    localparam coord_t Z_MAX_RST = 32'sd400;

endpackage
`default_nettype wire

// ----- rtl/core/cpd_clamp.sv -----
// Clamps one signed coordinate to its minimum first and then to its maximum.
`default_nettype none
module cpd_clamp (
    input  wire cpd_pkg::coord_t value,
    input  wire cpd_pkg::coord_t lo,
    input  wire cpd_pkg::coord_t hi,
    output cpd_pkg::coord_t      clamped
);
    import cpd_pkg::*;

    coord_t raised;

    // With the minimum above the maximum, the maximum wins.
    always_comb begin
        raised  = (value <= lo) ? lo : value;
        clamped = (hi <= raised) ? hi : raised;
    end

endmodule
`default_nettype wire

// ----- rtl/core/coordinate_packet_deframer_core.sv -----
// Top level of the coordinate packet deframer: header hunt, packet collection and output.
//
// Channel   Dir  Beat content
// s_*       in   one received byte
// m_*       out  command, clamped X, Y, Z; tuser carries the checksum flag
// APB       in   six 32-bit clamp bound registers at byte addresses 0 to 20
//
// Every input beat is taken at one beat per cycle, except while a trailer byte stalls.
// The trailer byte produces a result beat, registered in the output register in the cycle after it is taken.
// A non-trailer byte is accepted even while a result beat waits in the output register.
// Only a trailer byte stalls, and only while the previous result beat has not been taken.
// Reset returns the block to header hunting and loads the default clamp bounds.
`default_nettype none
module coordinate_packet_deframer_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // s_tdata: rx_byte[7:0]
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,
    // m_tdata: command[7:0], x_pos[39:8], y_pos[71:40], z_pos[103:72]
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [103:0]                     m_tdata,
    // m_tuser: checksum_ok[0]
    output logic                             m_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cpd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import cpd_pkg::*;

    coord_t x_min_reg, x_max_reg, y_min_reg, y_max_reg, z_min_reg, z_max_reg;

    logic [3:0] pos_reg, pos_next;
    logic       prev_reg, prev_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] cmd_reg, cmd_next;
    coord_t     x_reg, x_next, y_reg, y_next, z_reg, z_next;

    logic         out_valid_reg;
    logic [103:0] out_data_reg;
    logic         out_ok_reg;

    logic   in_beat;
    logic   trailer;
    logic   cfg_write;
    logic [2:0] reg_idx;
    coord_t x_clamped, y_clamped, z_clamped;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= X_MIN_RST;
            x_max_reg <= X_MAX_RST;
            y_min_reg <= Y_MIN_RST;
            y_max_reg <= Y_MAX_RST;
            z_min_reg <= Z_MIN_RST;
            z_max_reg <= Z_MAX_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_X_MIN: x_min_reg <= pwdata;
                REG_X_MAX: x_max_reg <= pwdata;
                REG_Y_MIN: y_min_reg <= pwdata;
                REG_Y_MAX: y_max_reg <= pwdata;
                REG_Z_MIN: z_min_reg <= pwdata;
                REG_Z_MAX: z_max_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_X_MIN: prdata = x_min_reg;
            REG_X_MAX: prdata = x_max_reg;
            REG_Y_MIN: prdata = y_min_reg;
            REG_Y_MAX: prdata = y_max_reg;
            REG_Z_MIN: prdata = z_min_reg;
            REG_Z_MAX: prdata = z_max_reg;
            default:   prdata = 32'd0;
        endcase
    end

    assign trailer  = (pos_reg == POS_LAST);
    assign s_tready = !(trailer && out_valid_reg && !m_tready);
    assign in_beat  = s_tvalid && s_tready;

    always_comb begin
        pos_next  = pos_reg;
        prev_next = prev_reg;
        sum_next  = sum_reg;
        cmd_next  = cmd_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (pos_reg inside {POS_HUNT, POS_UNUSED}) begin
            pos_next  = POS_HUNT;
            prev_next = 1'b0;
            if (s_tdata == HDR_BYTE) begin
                if (prev_reg) begin
                    pos_next = POS_CMD;
                    sum_next = 8'd0;
                    cmd_next = 8'd0;
                    x_next   = '0;
                    y_next   = '0;
                    z_next   = '0;
                end else begin
                    prev_next = 1'b1;
                end
            end
        end else if (trailer) begin
            pos_next  = POS_HUNT;
            prev_next = 1'b0;
        end else begin
            sum_next = sum_reg + s_tdata;
            pos_next = pos_reg + 4'd1;
            if (pos_reg == POS_CMD) begin
                cmd_next = s_tdata;
            end else if (pos_reg <= POS_X_LAST) begin
                x_next = {x_reg[23:0], s_tdata};
            end else if (pos_reg <= POS_Y_LAST) begin
                y_next = {y_reg[23:0], s_tdata};
            end else begin
                z_next = {z_reg[23:0], s_tdata};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HUNT;
            prev_reg <= 1'b0;
        end else if (in_beat) begin
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            sum_reg <= sum_next;
            cmd_reg <= cmd_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    cpd_clamp u_clamp_x (.value(x_reg), .lo(x_min_reg), .hi(x_max_reg), .clamped(x_clamped));
    cpd_clamp u_clamp_y (.value(y_reg), .lo(y_min_reg), .hi(y_max_reg), .clamped(y_clamped));
    cpd_clamp u_clamp_z (.value(z_reg), .lo(z_min_reg), .hi(z_max_reg), .clamped(z_clamped));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_beat && trailer) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && trailer) begin
            out_data_reg <= {z_clamped, y_clamped, x_clamped, cmd_reg};
            out_ok_reg   <= (~sum_reg == s_tdata);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    // A new result beat only follows a trailer byte.
    a_result_from_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(trailer && in_beat))
        else $error("result beat without a trailer byte");

    // The unused position code is never reached.
    a_no_unused_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != POS_UNUSED)
        else $error("byte position entered the unused code");

    // A pending header byte is only remembered while hunting.
    a_prev_only_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        prev_reg |-> (pos_reg == POS_HUNT))
        else $error("header flag set inside a packet");

    // A result beat that is not taken stays in the output register.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result beat lost or changed");

endmodule
`default_nettype wire
